@@ sv/erlm_pkg.sv @@
// Shared types and constants of the event rate limit monitor.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none
package erlm_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int ID_W         = 32;
    localparam int RATE_W       = 42;
    localparam int INST_W       = 7;
    localparam int IVL_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int RATE_SCALE   = 1000;
    localparam int DIV_STEPS    = RATE_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    // Input item kinds.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_LOAD   = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TID_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd3;

    // Evaluation phases of one report.
    localparam logic [1:0] PH_SRATE = 2'd0;
    localparam logic [1:0] PH_MRATE = 2'd1;
    localparam logic [1:0] PH_INST  = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       scan_start;
        logic       scan_rd;
        logic       commit;
        logic       tick_first;
        logic       tick_next;
        logic       mul_go;
        logic       div_go;
        logic       div_cap;
        logic       out_load;
        logic [1:0] op;
    } erlm_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic grp_rep;
        logic tick_grp;
        logic div_busy;
        logic res_room;
    } erlm_status_t;

endpackage
`default_nettype wire

@@ sv/erlm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on erlm_pkg for the operand widths.
`default_nettype none
module erlm_div
    import erlm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RATE_W-1:0] dividend,
    input  wire logic [IVL_W-1:0]  divisor,
    output logic                   busy,
    output logic [RATE_W-1:0]      quotient
);

    logic [RATE_W-1:0]    quo_reg;
    logic [IVL_W-1:0]     rem_reg;
    logic [IVL_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [IVL_W:0]       rem_sh;
    logic [IVL_W:0]       diff;
    logic                 ge;

    assign rem_sh = {rem_reg, quo_reg[RATE_W-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[RATE_W-2:0], ge};
            rem_reg <= ge ? diff[IVL_W-1:0] : rem_sh[IVL_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ sv/erlm_ctrl.sv @@
// Controller state machine of the event rate limit monitor.
// Depends on erlm_pkg for the command and status structs.
`default_nettype none
module erlm_ctrl
    import erlm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic [1:0]   s_kind,
    output logic              s_ready,
    input  wire erlm_status_t sts,
    output erlm_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_DRAIN  = 4'd2;
    localparam logic [3:0] ST_COMMIT = 4'd3;
    localparam logic [3:0] ST_CHECK  = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_DGO    = 4'd6;
    localparam logic [3:0] ST_DWAIT  = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] ph_reg, ph_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_SRATE;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        cmd.op     = ph_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_kind == KIND_SAMPLE || s_kind == KIND_LOAD) begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end else if (s_kind == KIND_TICK) begin
                        cmd.tick_first = 1'b1;
                        state_next     = ST_CHECK;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHECK: begin
                if (sts.grp_rep) begin
                    ph_next    = PH_SRATE;
                    state_next = ST_MUL;
                end else if (sts.tick_grp) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.tick_next = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul_go = 1'b1;
                state_next = ST_DGO;
            end
            ST_DGO: begin
                cmd.div_go = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!sts.div_busy) begin
                    cmd.div_cap = 1'b1;
                    if (ph_reg == PH_SRATE) begin
                        ph_next    = PH_MRATE;
                        state_next = ST_MUL;
                    end else if (ph_reg == PH_MRATE) begin
                        ph_next    = PH_INST;
                        state_next = ST_DGO;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (sts.res_room) begin
                    cmd.out_load = 1'b1;
                    if (sts.tick_grp) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.tick_next = 1'b1;
                        state_next    = ST_CHECK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/erlm_datapath.sv @@
// Datapath: key memories, hit marks, counters, rate arithmetic and result register.
// Depends on erlm_pkg and instantiates erlm_div.
`default_nettype none
module erlm_datapath
    import erlm_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire erlm_cmd_t             cmd,
    output erlm_status_t               sts,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [1:0]            s_kind,
    input  wire logic [ID_W-1:0]       s_cpu_id,
    input  wire logic [ID_W-1:0]       s_thread_id,
    input  wire logic                  s_load_group,
    input  wire logic [ID_W-1:0]       s_load_key,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_group,
    output logic [RATE_W-1:0]          m_sampled_rate,
    output logic [RATE_W-1:0]          m_matched_rate,
    output logic [INST_W-1:0]          m_active_instances,
    output logic                       m_exceeded,
    output logic                       m_last
);

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    // Configuration registers.
    logic             cpu_en_reg;
    logic             tid_en_reg;
    logic [IVL_W-1:0] interval_reg;
    logic [ID_W-1:0]  limit_reg;
    logic [1:0]       grp_en;

    // Captured input item.
    logic [1:0]      kind_reg;
    logic [ID_W-1:0] cpu_reg;
    logic [ID_W-1:0] tid_reg;
    logic            lgrp_reg;
    logic [ID_W-1:0] lkey_reg;

    // Key store and scan.
    logic [ID_W-1:0]     mem0 [MAX_KEYS];
    logic [ID_W-1:0]     mem1 [MAX_KEYS];
    logic [ID_W-1:0]     rd_data_reg [2];
    logic [CNT_W-1:0]    fill_reg [2];
    logic [MAX_KEYS-1:0] hit_reg [2];
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_d_reg;
    logic                rd_valid_reg;
    logic [1:0]          found_reg;
    logic [IDX_W-1:0]    found_idx_reg [2];
    logic [1:0]          match;
    logic [1:0]          mem_we;
    logic [ID_W-1:0]     cmp_key [2];

    // Counters.
    logic [ID_W-1:0]   sampled_reg [2];
    logic [ID_W-1:0]   matched_reg [2];
    logic [INST_W-1:0] inst_reg [2];
    logic              stopped_reg;

    // Tick evaluation.
    logic              tg_reg;
    logic [RATE_W-1:0] prod_reg;
    logic [RATE_W-1:0] srate_reg;
    logic [RATE_W-1:0] mrate_reg;
    logic              over_reg;
    logic [ID_W-1:0]   mul_src;
    logic [RATE_W-1:0] div_dividend;
    logic [IVL_W-1:0]  div_divisor;
    logic              div_busy;
    logic [RATE_W-1:0] div_quo;

    logic m_valid_reg;
    logic m_group_reg;
    logic [RATE_W-1:0] m_srate_reg;
    logic [RATE_W-1:0] m_mrate_reg;
    logic [INST_W-1:0] m_inst_reg;
    logic m_over_reg;
    logic m_last_reg;
    logic res_room;

    assign grp_en = {tid_en_reg, cpu_en_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_en_reg   <= 1'b0;
            tid_en_reg   <= 1'b0;
            interval_reg <= IVL_W'(RATE_SCALE);
            limit_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CPU_EN:   cpu_en_reg   <= cfg_wdata[0];
                CFG_TID_EN:   tid_en_reg   <= cfg_wdata[0];
                CFG_INTERVAL: interval_reg <= cfg_wdata[IVL_W-1:0];
                CFG_LIMIT:    limit_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            cpu_reg  <= s_cpu_id;
            tid_reg  <= s_thread_id;
            lgrp_reg <= s_load_group;
            lkey_reg <= s_load_key;
        end
    end

    // A load compares only against its own group; a sample against both.
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            if (kind_reg == KIND_LOAD) begin
                cmp_key[g] = lkey_reg;
                match[g]   = rd_valid_reg && (lgrp_reg == g[0])
                             && (CNT_W'(idx_d_reg) < fill_reg[g])
                             && (rd_data_reg[g] == lkey_reg);
            end else begin
                cmp_key[g] = (g == 0) ? cpu_reg : tid_reg;
                match[g]   = rd_valid_reg && (CNT_W'(idx_d_reg) < fill_reg[g])
                             && (rd_data_reg[g] == cmp_key[g]);
            end
            mem_we[g] = cmd.commit && (kind_reg == KIND_LOAD) && (lgrp_reg == g[0])
                        && !found_reg[g] && (fill_reg[g] != CNT_W'(MAX_KEYS));
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we[0]) begin
            mem0[fill_reg[0][IDX_W-1:0]] <= lkey_reg;
        end
        if (cmd.scan_rd) begin
            rd_data_reg[0] <= mem0[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we[1]) begin
            mem1[fill_reg[1][IDX_W-1:0]] <= lkey_reg;
        end
        if (cmd.scan_rd) begin
            rd_data_reg[1] <= mem1[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= '0;
        end else begin
            rd_valid_reg <= cmd.scan_rd;
            if (cmd.scan_start) begin
                idx_reg   <= '0;
                found_reg <= '0;
            end else begin
                if (cmd.scan_rd) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                for (int g = 0; g < 2; g++) begin
                    if (match[g]) begin
                        found_reg[g] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_d_reg <= idx_reg;
        for (int g = 0; g < 2; g++) begin
            if (match[g]) begin
                found_idx_reg[g] <= idx_d_reg;
            end
        end
    end

    // Counter, hit mark and fill updates, plus the per-group clear after a report.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < 2; g++) begin
                fill_reg[g]    <= '0;
                hit_reg[g]     <= '0;
                sampled_reg[g] <= '0;
                matched_reg[g] <= '0;
                inst_reg[g]    <= '0;
            end
            stopped_reg <= 1'b0;
        end else begin
            for (int g = 0; g < 2; g++) begin
                if (mem_we[g]) begin
                    fill_reg[g] <= fill_reg[g] + 1'b1;
                end
                if (cmd.commit && kind_reg == KIND_SAMPLE && grp_en[g] && !stopped_reg) begin
                    if (sampled_reg[g] != '1) begin
                        sampled_reg[g] <= sampled_reg[g] + 1'b1;
                    end
                    if (found_reg[g]) begin
                        if (matched_reg[g] != '1) begin
                            matched_reg[g] <= matched_reg[g] + 1'b1;
                        end
                        if (!hit_reg[g][found_idx_reg[g]]) begin
                            hit_reg[g][found_idx_reg[g]] <= 1'b1;
                            if (inst_reg[g] != '1) begin
                                inst_reg[g] <= inst_reg[g] + 1'b1;
                            end
                        end
                    end
                end
                if (cmd.out_load && tg_reg == g[0]) begin
                    hit_reg[g]     <= '0;
                    sampled_reg[g] <= '0;
                    matched_reg[g] <= '0;
                    inst_reg[g]    <= '0;
                end
            end
            if (cmd.out_load && over_reg) begin
                stopped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tg_reg <= 1'b0;
        end else if (cmd.tick_first) begin
            tg_reg <= 1'b0;
        end else if (cmd.tick_next) begin
            tg_reg <= 1'b1;
        end
    end

    assign mul_src = (cmd.op == PH_MRATE) ? matched_reg[tg_reg] : sampled_reg[tg_reg];

    always_ff @(posedge aclk) begin
        if (cmd.mul_go) begin
            prod_reg <= RATE_W'(mul_src) * RATE_W'(RATE_SCALE);
        end
    end

    always_comb begin
        if (cmd.op == PH_INST) begin
            div_dividend = mrate_reg;
            div_divisor  = IVL_W'(inst_reg[tg_reg]);
        end else begin
            div_dividend = prod_reg;
            div_divisor  = (interval_reg == '0) ? IVL_W'(1) : interval_reg;
        end
    end

    erlm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // A zero instance count never counts as an exceed.
    always_ff @(posedge aclk) begin
        if (cmd.div_cap) begin
            unique case (cmd.op)
                PH_SRATE: srate_reg <= div_quo;
                PH_MRATE: mrate_reg <= div_quo;
                PH_INST:  over_reg  <= (limit_reg != '0) && (inst_reg[tg_reg] != '0)
                                       && (div_quo > RATE_W'(limit_reg));
                default: begin
                end
            endcase
        end
    end

    assign res_room = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_group_reg <= tg_reg;
            m_srate_reg <= srate_reg;
            m_mrate_reg <= mrate_reg;
            m_inst_reg  <= inst_reg[tg_reg];
            m_over_reg  <= over_reg;
            m_last_reg  <= tg_reg || !(grp_en[1] && sampled_reg[1] != '0);
        end
    end

    assign sts.scan_last = (idx_reg == IDX_W'(MAX_KEYS - 1));
    assign sts.grp_rep   = grp_en[tg_reg] && (sampled_reg[tg_reg] != '0);
    assign sts.tick_grp  = tg_reg;
    assign sts.div_busy  = div_busy;
    assign sts.res_room  = res_room;

    assign m_valid            = m_valid_reg;
    assign m_group            = m_group_reg;
    assign m_sampled_rate     = m_srate_reg;
    assign m_matched_rate     = m_mrate_reg;
    assign m_active_instances = m_inst_reg;
    assign m_exceeded         = m_over_reg;
    assign m_last             = m_last_reg;

endmodule
`default_nettype wire

@@ sv/event_rate_limit_monitor_top.sv @@
// Event rate limit monitor: after a sample event or a key load, ready returns once the key
// memories are scanned one entry per cycle and the item is drained and committed; kind 3
// leaves the controller idle. A tick runs three 42-step divisions in the shared divider per
// reporting group, and a report waits for m_ready while the output register is full. Results
// wait in an output register, so the next item can be taken while the last report of a
// tick is still pending. No clearing pass is needed after reset.
// Depends on erlm_pkg, erlm_ctrl, erlm_datapath and erlm_div.
`default_nettype none
module event_rate_limit_monitor_top
    import erlm_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_kind,
    input  wire logic [ID_W-1:0]       s_cpu_id,
    input  wire logic [ID_W-1:0]       s_thread_id,
    input  wire logic                  s_load_group,
    input  wire logic [ID_W-1:0]       s_load_key,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_group,
    output logic [RATE_W-1:0]          m_sampled_rate,
    output logic [RATE_W-1:0]          m_matched_rate,
    output logic [INST_W-1:0]          m_active_instances,
    output logic                       m_exceeded,
    output logic                       m_last
);

    erlm_cmd_t    cmd;
    erlm_status_t sts;

    erlm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    erlm_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_kind             (s_kind),
        .s_cpu_id           (s_cpu_id),
        .s_thread_id        (s_thread_id),
        .s_load_group       (s_load_group),
        .s_load_key         (s_load_key),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_group            (m_group),
        .m_sampled_rate     (m_sampled_rate),
        .m_matched_rate     (m_matched_rate),
        .m_active_instances (m_active_instances),
        .m_exceeded         (m_exceeded),
        .m_last             (m_last)
    );

endmodule
`default_nettype wire

@@ sv/erlm_checker.sv @@
// Port-level checks of the event rate limit monitor, bound to the top level.
// Depends on erlm_pkg for field widths.
`default_nettype none
module erlm_checker
    import erlm_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [RATE_W-1:0] m_sampled_rate,
    input wire logic [RATE_W-1:0] m_matched_rate,
    input wire logic [INST_W-1:0] m_active_instances,
    input wire logic              m_exceeded
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_exceed_inst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_exceeded && m_active_instances == '0))
        else $error("exceed reported with no active instance");

    a_rate_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_matched_rate <= m_sampled_rate)
        else $error("matched rate above sampled rate");

endmodule

bind event_rate_limit_monitor_top erlm_checker u_erlm_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_sampled_rate     (m_sampled_rate),
    .m_matched_rate     (m_matched_rate),
    .m_active_instances (m_active_instances),
    .m_exceeded         (m_exceeded)
);
`default_nettype wire
